@@ src/msvs_pkg.sv @@
// Shared types, codes and helpers of the min-vruntime slice scheduler.
package msvs_pkg;

	// Default table depth and reset value of the slice register
	localparam int unsigned SLOTS_DEF   = 16;
	localparam logic [7:0]  SLICE_RESET = 8'd10;

	// Command codes of an input transaction
	localparam logic CMD_ADD      = 1'b0;
	localparam logic CMD_DISPATCH = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_ADDED      = 2'd0;
	localparam logic [1:0] ST_FULL       = 2'd1;
	localparam logic [1:0] ST_DISPATCHED = 2'd2;
	localparam logic [1:0] ST_EMPTY      = 2'd3;

	// Configuration register indexes
	localparam logic REG_TIME_SLICE = 1'b0;

	// Running best/free record handed from cell to cell during a sweep
	typedef struct packed {
		logic        best_found;
		logic [31:0] best_vtime;
		logic [31:0] best_order;
		logic [15:0] best_id;
		logic [15:0] best_burst;
		logic        free_found;
	} sweep_rec_t;

	// Slot contents written into one cell
	typedef struct packed {
		logic        valid;
		logic [15:0] id;
		logic [15:0] burst;
		logic [31:0] vtime;
		logic [31:0] order;
	} slot_wr_t;

	// 32-bit add that sticks at all ones
	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[32] ? '1 : sum[31:0];
	endfunction

endpackage

@@ src/msvs_in_if.sv @@
// Input channel: task commands.
interface msvs_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [15:0] task_id;
	logic [15:0] burst_length;

	modport source (output valid, cmd, task_id, burst_length, input ready);
	modport sink   (input valid, cmd, task_id, burst_length, output ready);
endinterface

@@ src/msvs_out_if.sv @@
// Output channel: one result per command.
interface msvs_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] chosen_id;
	logic [7:0]  run_length;
	logic [15:0] burst_left;
	logic        task_done;
	logic [31:0] now;

	modport source (output valid, status, chosen_id, run_length, burst_left, task_done, now,
		input ready);
	modport sink   (input valid, status, chosen_id, run_length, burst_left, task_done, now,
		output ready);
endinterface

@@ src/msvs_cell.sv @@
// One task slot of the chain: holds its entry and refines the passing sweep record.
module msvs_cell
	import msvs_pkg::*;
#(
	parameter int unsigned IDX_W = 4,
	parameter int unsigned INDEX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_in,
	input  sweep_rec_t       rec_in,
	input  logic [IDX_W-1:0] best_idx_in,
	input  logic [IDX_W-1:0] free_idx_in,
	output logic             step_out,
	output sweep_rec_t       rec_out,
	output logic [IDX_W-1:0] best_idx_out,
	output logic [IDX_W-1:0] free_idx_out,
	input  logic             wr_en,
	input  slot_wr_t         wr_data
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic        valid_q;
	logic [15:0] id_q;
	logic [15:0] burst_q;
	logic [31:0] vtime_q;
	logic [31:0] order_q;

	logic        take_best;
	logic        take_free;
	sweep_rec_t  rec_nxt;

	// Slot storage; only the valid bit needs reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_en) begin
			valid_q <= wr_data.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_q    <= wr_data.id;
			burst_q <= wr_data.burst;
			vtime_q <= wr_data.vtime;
			order_q <= wr_data.order;
		end
	end

	// Strictly better only, so an earlier slot keeps a full tie
	always_comb begin
		take_best = valid_q && (!rec_in.best_found || vtime_q < rec_in.best_vtime ||
			(vtime_q == rec_in.best_vtime && order_q < rec_in.best_order));
		take_free = !valid_q && !rec_in.free_found;
		rec_nxt   = rec_in;
		if (take_best) begin
			rec_nxt.best_found = 1'b1;
			rec_nxt.best_vtime = vtime_q;
			rec_nxt.best_order = order_q;
			rec_nxt.best_id    = id_q;
			rec_nxt.best_burst = burst_q;
		end
		if (take_free) begin
			rec_nxt.free_found = 1'b1;
		end
	end

	// Hand the record to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_out <= 1'b0;
		end else begin
			step_out <= step_in;
		end
	end

	always_ff @(posedge clk) begin
		rec_out      <= rec_nxt;
		best_idx_out <= take_best ? MY_IDX : best_idx_in;
		free_idx_out <= take_free ? MY_IDX : free_idx_in;
	end

endmodule

@@ src/min_vruntime_slice_scheduler_top.sv @@
// Top level of the min-vruntime slice scheduler: control, counters, chain of slot cells.
//
// Usage:
//  - in_ch carries commands: cmd 0 adds task_id with burst_length, cmd 1 dispatches
//    the queued task with the least virtual runtime (earliest insertion wins a tie).
//  - out_ch returns exactly one result transaction per command: status, chosen_id,
//    run_length, burst_left, task_done and the global time now.
//  - The APB port holds time_slice at byte address 0 (reset 10, zero acts as 1).
//  - Each command launches one sweep record down the row of SLOTS cells, one cell
//    per cycle; the record finds the least-runtime task and the lowest free slot.
//  - A result follows acceptance after the sweep through the cell chain and the
//    write-back step. One command is in the block at a time, so a new command is
//    accepted only after the previous one has been written back.
//  - The result sits in an output register: the next command is accepted while it
//    waits. If the receiver stalls longer, the following result holds in the
//    write-back step until the output register frees.
//  - Reset clears all slots, the insertion counter, the global time and the slice
//    register to its default; no clearing pass is needed.
module min_vruntime_slice_scheduler_top
	import msvs_pkg::*;
#(
	parameter int unsigned SLOTS = SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	msvs_in_if.sink     in_ch,
	msvs_out_if.source  out_ch
);

	localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_UPDATE
	} state_t;

	state_t state_q;

	logic [7:0]  slice_q;
	logic        cmd_q;
	logic [15:0] id_q;
	logic [15:0] burst_q;
	logic        start_q;
	sweep_rec_t  fin_q;
	logic [IDX_W-1:0] fin_best_q;
	logic [IDX_W-1:0] fin_free_q;
	logic [31:0] insert_count_q;
	logic [31:0] global_time_q;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [15:0] chosen_id_q;
	logic [7:0]  run_length_q;
	logic [15:0] burst_left_q;
	logic        task_done_q;
	logic [31:0] now_q;

	// Chain wiring
	logic             step_w     [SLOTS+1];
	sweep_rec_t       rec_w      [SLOTS+1];
	logic [IDX_W-1:0] best_idx_w [SLOTS+1];
	logic [IDX_W-1:0] free_idx_w [SLOTS+1];
	logic [SLOTS-1:0] wr_en;
	slot_wr_t         wr_data;

	logic        in_fire;
	logic        upd_fire;
	logic [7:0]  slice_eff;
	logic [15:0] run_full;
	logic [15:0] left;
	logic [31:0] vtime_new;
	logic [31:0] time_new;
	logic [31:0] count_inc;

	// APB register access
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TIME_SLICE) ? {24'd0, slice_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_q <= SLICE_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_TIME_SLICE) begin
			slice_q <= pwdata[7:0];
		end
	end

	// Handshakes
	assign in_ch.ready = (state_q == S_IDLE);
	assign in_fire     = in_ch.valid && (state_q == S_IDLE);
	assign upd_fire    = (state_q == S_UPDATE) && (!out_valid_q || out_ch.ready);

	// Run length and saturating updates for a dispatch
	always_comb begin
		slice_eff = (slice_q == 8'd0) ? 8'd1 : slice_q;
		run_full  = (fin_q.best_burst < {8'd0, slice_eff}) ? fin_q.best_burst
			: {8'd0, slice_eff};
		left      = fin_q.best_burst - run_full;
		vtime_new = sat_add32(fin_q.best_vtime, {16'd0, run_full});
		time_new  = sat_add32(global_time_q, {16'd0, run_full});
		count_inc = sat_add32(insert_count_q, 32'd1);
	end

	// Cell write-back at the end of a command
	always_comb begin
		wr_en   = '0;
		wr_data = '0;
		if (cmd_q == CMD_ADD) begin
			wr_data.valid = 1'b1;
			wr_data.id    = id_q;
			wr_data.burst = burst_q;
			wr_data.vtime = 32'd0;
			wr_data.order = insert_count_q;
			if (upd_fire && fin_q.free_found) begin
				wr_en[fin_free_q] = 1'b1;
			end
		end else begin
			wr_data.valid = (left != 16'd0);
			wr_data.id    = fin_q.best_id;
			wr_data.burst = left;
			wr_data.vtime = vtime_new;
			wr_data.order = insert_count_q;
			if (upd_fire && fin_q.best_found) begin
				wr_en[fin_best_q] = 1'b1;
			end
		end
	end

	// Sequencer, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			start_q        <= 1'b0;
			insert_count_q <= 32'd0;
			global_time_q  <= 32'd0;
			out_valid_q    <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						start_q <= 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (step_w[SLOTS]) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					if (upd_fire) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (cmd_q == CMD_ADD) begin
							if (fin_q.free_found) begin
								insert_count_q <= count_inc;
							end
						end else if (fin_q.best_found) begin
							global_time_q <= time_new;
							if (left != 16'd0) begin
								insert_count_q <= count_inc;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q   <= in_ch.cmd;
			id_q    <= in_ch.task_id;
			burst_q <= in_ch.burst_length;
		end
		if (state_q == S_SCAN && step_w[SLOTS]) begin
			fin_q      <= rec_w[SLOTS];
			fin_best_q <= best_idx_w[SLOTS];
			fin_free_q <= free_idx_w[SLOTS];
		end
		if (upd_fire) begin
			status_q     <= ST_ADDED;
			chosen_id_q  <= 16'd0;
			run_length_q <= 8'd0;
			burst_left_q <= 16'd0;
			task_done_q  <= 1'b0;
			now_q        <= global_time_q;
			if (cmd_q == CMD_ADD) begin
				status_q <= fin_q.free_found ? ST_ADDED : ST_FULL;
			end else if (!fin_q.best_found) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q     <= ST_DISPATCHED;
				chosen_id_q  <= fin_q.best_id;
				run_length_q <= run_full[7:0];
				burst_left_q <= left;
				task_done_q  <= (left == 16'd0);
				now_q        <= time_new;
			end
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.status     = status_q;
	assign out_ch.chosen_id  = chosen_id_q;
	assign out_ch.run_length = run_length_q;
	assign out_ch.burst_left = burst_left_q;
	assign out_ch.task_done  = task_done_q;
	assign out_ch.now        = now_q;

	// Row of slot cells; the sweep enters at cell 0 with an empty record
	assign step_w[0]     = start_q;
	assign rec_w[0]      = '0;
	assign best_idx_w[0] = '0;
	assign free_idx_w[0] = '0;

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		msvs_cell #(
			.IDX_W (IDX_W),
			.INDEX (g)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.step_in      (step_w[g]),
			.rec_in       (rec_w[g]),
			.best_idx_in  (best_idx_w[g]),
			.free_idx_in  (free_idx_w[g]),
			.step_out     (step_w[g+1]),
			.rec_out      (rec_w[g+1]),
			.best_idx_out (best_idx_w[g+1]),
			.free_idx_out (free_idx_w[g+1]),
			.wr_en        (wr_en[g]),
			.wr_data      (wr_data)
		);
	end

endmodule
